[rtl/fpgs_pkg.sv]
// Shared types, constants and rule tables of the fuzzy PID gain scheduler.
// Used by fpgs_div and fuzzy_pid_gain_scheduler_unit.
package fpgs_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int ERR_W     = SAMPLE_W + 1;
    localparam int CHG_W     = SAMPLE_W + 2;
    localparam int REG_W     = 24;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = 3;
    localparam int SET_COUNT = 7;
    localparam int X_W       = 19;
    localparam int MUL_A_W   = REG_W + 1;
    localparam int MUL_B_W   = X_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MF_W      = 13;
    localparam int WSUM_W    = 17;
    localparam int ASUM_W    = 15;
    localparam int DIVD_W    = 32;
    localparam int GAIN_MAX  = 16777215;
    localparam int DOMAIN_Q16 = 196608;
    localparam int MF_ONE    = 4096;

    localparam logic [REG_IDX_W-1:0] REG_ERROR_SCALE  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CHANGE_SCALE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KP_SCALE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BASE_KP      = 3'd5;

    typedef logic signed [2:0] centre_t;
    typedef centre_t rule_table_t [0:SET_COUNT-1][0:SET_COUNT-1];

    localparam rule_table_t KP_TABLE = '{
        '{ 3,  3,  2,  2,  2,  0,  0},
        '{ 3,  3,  2,  1,  1,  0, -1},
        '{ 2,  2,  2,  1,  0, -1, -1},
        '{ 2,  2,  1,  0, -1, -2, -2},
        '{ 1,  1,  0, -1, -1, -2, -2},
        '{ 1,  0, -1, -2, -2, -2, -3},
        '{ 0,  0, -2, -2, -2, -3, -3}};
    localparam rule_table_t KI_TABLE = '{
        '{-3, -3, -2, -2, -1,  0,  0},
        '{-3, -3, -2, -1, -1,  0,  0},
        '{-3, -2, -1, -1,  0,  1,  1},
        '{-2, -2, -1,  0,  1,  2,  2},
        '{-2, -1,  0,  1,  1,  3,  3},
        '{ 0,  0,  1,  1,  2,  3,  3},
        '{ 0,  0,  1,  2,  2,  3,  3}};
    localparam rule_table_t KD_TABLE = '{
        '{ 3,  3,  2,  1,  0, -1, -2},
        '{ 3,  3,  2,  1,  0, -1, -2},
        '{ 2,  2,  1,  0, -1, -2, -2},
        '{ 1,  1,  0, -1, -1, -2, -2},
        '{ 0,  0, -1, -2, -2, -3, -3},
        '{-1, -1, -2, -3, -3, -3, -3},
        '{-2, -2, -3, -3, -3, -3, -3}};

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[rtl/fpgs_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fpgs_pkg for widths and the status struct.
module fpgs_div
    import fpgs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [ASUM_W-1:0] divisor,
    output logic [DIVD_W-1:0] quotient,
    output div_status_t       status
);

    logic [DIVD_W-1:0] q_reg, q_next;
    logic [ASUM_W-1:0] rem_reg, rem_next;
    logic [ASUM_W-1:0] dvs_reg;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ASUM_W:0]   trial;
    logic              ge;

    assign trial = {rem_reg, q_reg[DIVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DIVD_W-2:0], ge};
            rem_next = ge ? ASUM_W'(trial - {1'b0, dvs_reg}) : trial[ASUM_W-1:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient    = q_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[rtl/fuzzy_pid_gain_scheduler_unit.sv]
// Fuzzy self-tuning PID gain scheduler: top level with sequencer and shared multiplier.
// Depends on fpgs_pkg and fpgs_div.
//
// Input stream (s_*): one transfer carries a measurement and a setpoint. The block
// forms the error and its change against the previous error, fuzzifies both over
// seven triangular sets, runs min inference over the 7x7 rule tables for kp, ki
// and kd and defuzzifies each by a weighted average.
// Output stream (m_*): one transfer per input carries the three adjusted gains.
// Configuration: cfg_we writes cfg_data into register cfg_addr; write only while idle.
// Three divisions run in turn in the shared serial divider, each with its start, wait
// and adjustment steps; one 25x19 multiplier serves all five products. s_tready is
// high only while the sequencer is idle, so a new input is taken only once the
// sequencer has finished the last one.
// If the receiver stalls, the finished result waits in the output register and
// the sequencer holds at its last step until the register is free.
// Reset clears the previous error and loads the register reset values.
module fuzzy_pid_gain_scheduler_unit
    import fpgs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // measurement[15:0], setpoint[31:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // gain_kp[23:0], gain_ki[47:24], gain_kd[71:48]
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_addr,
    input  logic [REG_W-1:0]     cfg_data
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_MUL_E    = 4'd1;
    localparam logic [3:0] S_MUL_C    = 4'd2;
    localparam logic [3:0] S_RULES    = 4'd3;
    localparam logic [3:0] S_DIV_GO   = 4'd4;
    localparam logic [3:0] S_DIV_WAIT = 4'd5;
    localparam logic [3:0] S_ADJ_MUL  = 4'd6;
    localparam logic [3:0] S_ADJ      = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]               state_reg, state_next;
    logic [REG_W-1:0]         cfg_reg [0:REG_COUNT-1];
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [CHG_W-1:0]  chg_reg;
    logic signed [X_W-1:0]    xe_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [WSUM_W-1:0] wsum_reg [0:2];
    logic [ASUM_W-1:0]        asum_reg;
    logic [1:0]               tsel_reg;
    logic signed [X_W-1:0]    crisp_reg;
    logic [REG_W-1:0]         gain_reg [0:2];
    logic                     out_valid_reg;
    logic [71:0]              out_data_reg;

    logic signed [SAMPLE_W-1:0] meas, sp;
    logic signed [ERR_W-1:0]    err_now;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [X_W-1:0]      x_clamp;
    logic signed [X_W-1:0]      xc;
    logic [2:0]                 ke_i0, ke_i1, kc_i0, kc_i1;
    logic [MF_W-1:0]            me0, me1, mc0, mc1;
    logic signed [WSUM_W-1:0]   wsum_c [0:2];
    logic [ASUM_W-1:0]          asum_c;
    logic signed [WSUM_W-1:0]   wsel;
    logic [WSUM_W-1:0]          wabs;
    logic [DIVD_W-1:0]          quo;
    div_status_t                div_st;
    logic                       div_start;
    logic [PROD_W-1:0]          pmag;
    logic signed [29:0]         delta, gsum;
    logic [REG_W-1:0]           gain_new;
    logic                       accept;

    assign meas    = s_tdata[15:0];
    assign sp      = s_tdata[31:16];
    assign err_now = ERR_W'(sp) - ERR_W'(meas);
    assign accept  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Saturate a scaled product into the fuzzy domain [-3, 3] in Q.16.
    function automatic logic signed [X_W-1:0] clamp_x(input logic signed [PROD_W-1:0] p);
        logic signed [X_W-1:0] r;
        if (p > PROD_W'(DOMAIN_Q16))
            r = X_W'(DOMAIN_Q16);
        else if (p < -PROD_W'(DOMAIN_Q16))
            r = -X_W'(DOMAIN_Q16);
        else
            r = p[X_W-1:0];
        return r;
    endfunction

    // Two neighboring sets carry all membership; the top edge gives PB alone.
    function automatic void fuzz(input logic signed [X_W-1:0] x, output logic [2:0] i0,
                                 output logic [2:0] i1, output logic [MF_W-1:0] m0,
                                 output logic [MF_W-1:0] m1);
        logic [X_W-1:0] u;
        u = X_W'(x + X_W'(DOMAIN_Q16));
        if (u[18:16] >= 3'd6)
        begin
            i0 = 3'd6;
            i1 = 3'd6;
            m0 = MF_W'(MF_ONE);
            m1 = '0;
        end
        else
        begin
            i0 = u[18:16];
            i1 = u[18:16] + 3'd1;
            m1 = {1'b0, u[15:4]};
            m0 = MF_W'(MF_ONE) - {1'b0, u[15:4]};
        end
    endfunction

    assign xc = clamp_x(prod_reg);

    always_comb
    begin
        logic [MF_W-1:0] a;
        logic [2:0]      ie, ic;
        logic            fire;
        fuzz(xe_reg, ke_i0, ke_i1, me0, me1);
        fuzz(xc, kc_i0, kc_i1, mc0, mc1);
        asum_c = '0;
        for (int t = 0; t < 3; t++)
            wsum_c[t] = '0;
        for (int r = 0; r < 4; r++)
        begin
            ie = r[1] ? ke_i1 : ke_i0;
            ic = r[0] ? kc_i1 : kc_i0;
            fire = ((r[1] ? me1 : me0) != '0) && ((r[0] ? mc1 : mc0) != '0);
            a = ((r[1] ? me1 : me0) < (r[0] ? mc1 : mc0)) ? (r[1] ? me1 : me0)
                                                          : (r[0] ? mc1 : mc0);
            if (fire)
            begin
                asum_c    = asum_c + ASUM_W'(a);
                wsum_c[0] = wsum_c[0] + $signed({4'b0, a}) * WSUM_W'(KP_TABLE[ie][ic]);
                wsum_c[1] = wsum_c[1] + $signed({4'b0, a}) * WSUM_W'(KI_TABLE[ie][ic]);
                wsum_c[2] = wsum_c[2] + $signed({4'b0, a}) * WSUM_W'(KD_TABLE[ie][ic]);
            end
        end
    end

    // Shared multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL_E:
            begin
                mul_a = {1'b0, cfg_reg[REG_ERROR_SCALE]};
                mul_b = MUL_B_W'(err_reg);
            end
            S_MUL_C:
            begin
                mul_a = {1'b0, cfg_reg[REG_CHANGE_SCALE]};
                mul_b = MUL_B_W'(chg_reg);
            end
            S_ADJ_MUL:
            begin
                mul_a = MUL_A_W'($signed(cfg_reg[REG_KP_SCALE + REG_IDX_W'(tsel_reg)]));
                mul_b = crisp_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign x_clamp = clamp_x(prod_reg);
    assign wsel    = wsum_reg[tsel_reg];
    assign wabs    = wsel[WSUM_W-1] ? WSUM_W'(-wsel) : WSUM_W'(wsel);
    assign div_start = (state_reg == S_DIV_GO);

    fpgs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({wabs[15:0], 16'b0}),
        .divisor  (asum_reg),
        .quotient (quo),
        .status   (div_st)
    );

    // Adjustment truncates toward zero, then the sum is clamped to the gain range.
    assign pmag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign delta = prod_reg[PROD_W-1] ? -$signed({2'b0, pmag[43:16]})
                                      : $signed({2'b0, pmag[43:16]});
    assign gsum  = $signed({6'b0, cfg_reg[REG_BASE_KP + REG_IDX_W'(tsel_reg)]}) + delta;
    assign gain_new = gsum[29] ? '0 :
                      (gsum > 30'(GAIN_MAX)) ? REG_W'(GAIN_MAX) : gsum[REG_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (accept) state_next = S_MUL_E;
            S_MUL_E:    state_next = S_MUL_C;
            S_MUL_C:    state_next = S_RULES;
            S_RULES:    state_next = S_DIV_GO;
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT: if (div_st.done) state_next = S_ADJ_MUL;
            S_ADJ_MUL:  state_next = S_ADJ;
            S_ADJ:      state_next = (tsel_reg == 2'd2) ? S_DONE : S_DIV_GO;
            S_DONE:     if (!out_valid_reg || m_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            tsel_reg      <= '0;
            for (int i = 0; i < REG_COUNT; i++)
                cfg_reg[i] <= (i == int'(REG_ERROR_SCALE) || i == int'(REG_CHANGE_SCALE)) ?
                              REG_W'(65536) : '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cfg_reg[cfg_addr] <= cfg_data;
            if (accept)
                prev_err_reg <= err_now;
            if (state_reg == S_RULES)
                tsel_reg <= '0;
            else if (state_reg == S_ADJ)
                tsel_reg <= tsel_reg + 2'd1;
            if (state_reg == S_DONE && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            err_reg <= err_now;
            chg_reg <= CHG_W'(err_now) - CHG_W'(prev_err_reg);
        end
        if (state_reg == S_MUL_C)
            xe_reg <= x_clamp;
        if (state_reg == S_RULES)
        begin
            asum_reg <= asum_c;
            for (int t = 0; t < 3; t++)
                wsum_reg[t] <= wsum_c[t];
        end
        if (state_reg == S_DIV_WAIT && div_st.done)
        begin
            if (asum_reg == '0)
                crisp_reg <= '0;
            else
                crisp_reg <= wsel[WSUM_W-1] ? -$signed(quo[X_W-1:0]) : $signed(quo[X_W-1:0]);
        end
        if (state_reg == S_ADJ)
            gain_reg[tsel_reg] <= gain_new;
        if (state_reg == S_DONE && (!out_valid_reg || m_tready))
            out_data_reg <= {gain_reg[2], gain_reg[1], gain_reg[0]};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // A transfer in always starts the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_MUL_E)
        else $error("sequencer did not start after input transfer");

    // The divider finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> state_reg == S_DIV_WAIT)
        else $error("divider result outside its wait step");

    // The divider is never busy while the block is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !div_st.busy)
        else $error("divider busy while idle");

endmodule
